// ===== design/dae_pkg.sv =====
// shared types, constants and helpers of the dual envelope generator
`default_nettype none
package dae_pkg;

  localparam int unsigned FRAME_BITS_DEF      = 20;
  localparam int unsigned LEVEL_FRAC_BITS_DEF = 23;
  localparam int unsigned CFG_FRAME_W         = 20;
  localparam int unsigned Q15_W               = 16;
  localparam int unsigned CFG_IDX_W           = 3;
  localparam int unsigned CFG_DATA_W          = 20;
  localparam logic [Q15_W-1:0] Q15_ONE        = 16'h8000;

  typedef struct packed {
    logic [2:0]       action;
    logic [Q15_W-1:0] peak_level;
  } in_t;

  typedef struct packed {
    logic [Q15_W-1:0] amp_level;
    logic [Q15_W-1:0] mod_level;
    logic [2:0]       amp_phase;
  } out_t;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_NOTE_ON,
    KIND_RETRIG,
    KIND_LEGATO,
    KIND_NOTE_OFF,
    KIND_STOP,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [Q15_W-1:0] peak;
  } item_t;

  typedef struct packed {
    logic [CFG_FRAME_W-1:0] attack_frames;
    logic [CFG_FRAME_W-1:0] decay_frames;
    logic [Q15_W-1:0]       sustain_level;
    logic [CFG_FRAME_W-1:0] release_frames;
    logic [CFG_FRAME_W-1:0] mod_attack_frames;
    logic [CFG_FRAME_W-1:0] mod_decay_frames;
    logic [Q15_W-1:0]       mod_sustain_level;
    logic [CFG_FRAME_W-1:0] mod_release_frames;
  } cfg_t;

  function automatic logic [Q15_W-1:0] sat_q15(input logic [Q15_W-1:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

endpackage
`default_nettype wire

// ===== design/dae_front.sv =====
// front end: accepts items, classifies the action and queues them
`default_nettype none
module dae_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dae_pkg::in_t  in_data_i,
  output logic          item_valid_o,
  input  logic          item_pop_i,
  output dae_pkg::item_t item_o
);
  import dae_pkg::*;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_NOTE_ON  = 3'd1,
    ACT_RETRIG   = 3'd2,
    ACT_LEGATO   = 3'd3,
    ACT_NOTE_OFF = 3'd4,
    ACT_STOP     = 3'd5
  } action_e;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      item_in;

  always_comb begin
    item_in.peak = sat_q15(in_data_i.peak_level);
    unique case (action_e'(in_data_i.action))
      ACT_TICK:     item_in.kind = KIND_TICK;
      ACT_NOTE_ON:  item_in.kind = KIND_NOTE_ON;
      ACT_RETRIG:   item_in.kind = KIND_RETRIG;
      ACT_LEGATO:   item_in.kind = KIND_LEGATO;
      ACT_NOTE_OFF: item_in.kind = KIND_NOTE_OFF;
      ACT_STOP:     item_in.kind = KIND_STOP;
      default:      item_in.kind = KIND_NOP;
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_in;
  end

endmodule
`default_nettype wire

// ===== design/dae_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module dae_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [VW-1:0] rem_q, den_q;
  logic [DW-1:0] quo_q;
  logic [CW-1:0] step_q;
  logic          busy_q;
  logic [VW:0]   trial, diffv;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diffv = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + CW'(1);
      if (step_q == CW'(DW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diffv[VW-1:0] : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== design/dae_back.sv =====
// back end: envelope state, event handling and tick sequencing
`default_nettype none
module dae_back #(
  parameter int unsigned FRAME_BITS      = dae_pkg::FRAME_BITS_DEF,
  parameter int unsigned LEVEL_FRAC_BITS = dae_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  input  dae_pkg::item_t item_i,
  input  dae_pkg::cfg_t  cfg_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dae_pkg::out_t  out_data_o
);
  import dae_pkg::*;

  localparam int unsigned LB = LEVEL_FRAC_BITS + 1;
  localparam int unsigned FB = FRAME_BITS;
  localparam int unsigned SH = LEVEL_FRAC_BITS - 15;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [2:0] {S_WAIT, S_PREP, S_SETUP, S_DIV, S_DONE} seq_e;
  typedef enum logic [1:0] {PL_SEG, PL_SET, PL_HOLD} plan_kind_e;

  typedef struct packed {
    plan_kind_e    kind;
    logic [LB-1:0] target;
    logic [FB-1:0] frames;
    stage_e        next;
  } plan_t;

  seq_e          seq_q;
  stage_e        amp_stage_q, mod_stage_q;
  logic [FB-1:0] amp_cnt_q, mod_cnt_q;
  logic [LB-1:0] amp_val_q, mod_val_q;
  logic [15:0]   peak_q;
  logic [31:0]   prod_q;
  out_t          out_q;
  logic          out_valid_q;

  logic [LB-1:0] peak_lv, one_lv, amp_sus_lv, mod_sus_lv;
  plan_t         amp_plan, mod_plan;

  assign peak_lv    = LB'(peak_q) << SH;
  assign one_lv     = LB'(Q15_ONE) << SH;
  assign mod_sus_lv = LB'(sat_q15(cfg_i.mod_sustain_level)) << SH;

  // peak times sustain is Q2.30, rescaled to the level format
  generate
    if (LEVEL_FRAC_BITS >= 30) begin : g_sus_up
      assign amp_sus_lv = LB'(prod_q) << (LEVEL_FRAC_BITS - 30);
    end else begin : g_sus_dn
      assign amp_sus_lv = LB'(prod_q >> (30 - LEVEL_FRAC_BITS));
    end
  endgenerate

  always_comb begin
    amp_plan = '{kind: PL_SET, target: '0, frames: '0, next: ST_IDLE};
    unique case (amp_stage_q)
      ST_ATTACK:  amp_plan = '{PL_SEG, peak_lv, FB'(cfg_i.attack_frames), ST_DECAY};
      ST_DECAY:   amp_plan = '{PL_SEG, amp_sus_lv, FB'(cfg_i.decay_frames), ST_SUSTAIN};
      ST_SUSTAIN: amp_plan = '{PL_SET, amp_sus_lv, '0, ST_SUSTAIN};
      ST_RELEASE: amp_plan = '{PL_SEG, '0, FB'(cfg_i.release_frames), ST_IDLE};
      default:    amp_plan = '{PL_SET, '0, '0, ST_IDLE};
    endcase
  end

  always_comb begin
    mod_plan = '{kind: PL_HOLD, target: '0, frames: '0, next: ST_IDLE};
    unique case (mod_stage_q)
      ST_ATTACK:  mod_plan = '{PL_SEG, one_lv, FB'(cfg_i.mod_attack_frames), ST_DECAY};
      ST_DECAY:   mod_plan = '{PL_SEG, mod_sus_lv, FB'(cfg_i.mod_decay_frames), ST_SUSTAIN};
      ST_SUSTAIN: mod_plan = '{PL_SET, mod_sus_lv, '0, ST_SUSTAIN};
      ST_RELEASE: mod_plan = '{PL_SEG, '0, FB'(cfg_i.mod_release_frames), ST_IDLE};
      default:    mod_plan = '{PL_HOLD, '0, '0, ST_IDLE};
    endcase
  end

  // amplitude ramp step
  logic          amp_jump, amp_ramp, amp_neg, amp_fin, amp_busy;
  logic [LB:0]   amp_diff, amp_sum;
  logic [LB-1:0] amp_mag, amp_quo;
  logic [FB:0]   amp_cnt1;

  assign amp_jump = (amp_cnt_q >= amp_plan.frames);
  assign amp_ramp = (amp_plan.kind == PL_SEG) && !amp_jump;
  assign amp_diff = {1'b0, amp_plan.target} - {1'b0, amp_val_q};
  assign amp_neg  = amp_diff[LB];
  assign amp_mag  = amp_neg ? LB'(-amp_diff) : amp_diff[LB-1:0];
  assign amp_sum  = amp_neg ? ({1'b0, amp_val_q} - {1'b0, amp_quo})
                            : ({1'b0, amp_val_q} + {1'b0, amp_quo});
  assign amp_cnt1 = {1'b0, amp_cnt_q} + (FB+1)'(1);
  assign amp_fin  = (amp_cnt1 >= {1'b0, amp_plan.frames});

  // filter envelope ramp step
  logic          mod_jump, mod_ramp, mod_neg, mod_fin, mod_busy;
  logic [LB:0]   mod_diff, mod_sum;
  logic [LB-1:0] mod_mag, mod_quo;
  logic [FB:0]   mod_cnt1;

  assign mod_jump = (mod_cnt_q >= mod_plan.frames);
  assign mod_ramp = (mod_plan.kind == PL_SEG) && !mod_jump;
  assign mod_diff = {1'b0, mod_plan.target} - {1'b0, mod_val_q};
  assign mod_neg  = mod_diff[LB];
  assign mod_mag  = mod_neg ? LB'(-mod_diff) : mod_diff[LB-1:0];
  assign mod_sum  = mod_neg ? ({1'b0, mod_val_q} - {1'b0, mod_quo})
                            : ({1'b0, mod_val_q} + {1'b0, mod_quo});
  assign mod_cnt1 = {1'b0, mod_cnt_q} + (FB+1)'(1);
  assign mod_fin  = (mod_cnt1 >= {1'b0, mod_plan.frames});

  dae_div #(.DW(LB), .VW(FB)) u_amp_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((seq_q == S_SETUP) && amp_ramp),
    .dividend_i (amp_mag),
    .divisor_i  (amp_plan.frames - amp_cnt_q),
    .busy_o     (amp_busy),
    .quotient_o (amp_quo)
  );

  dae_div #(.DW(LB), .VW(FB)) u_mod_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((seq_q == S_SETUP) && mod_ramp),
    .dividend_i (mod_mag),
    .divisor_i  (mod_plan.frames - mod_cnt_q),
    .busy_o     (mod_busy),
    .quotient_o (mod_quo)
  );

  logic out_load;
  assign out_load   = (seq_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign item_pop_o = (seq_q == S_WAIT) && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_WAIT;
      amp_stage_q <= ST_IDLE;
      mod_stage_q <= ST_IDLE;
      amp_cnt_q   <= '0;
      mod_cnt_q   <= '0;
      amp_val_q   <= '0;
      mod_val_q   <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      unique case (seq_q)
        S_WAIT: begin
          if (item_valid_i) begin
            seq_q <= (item_i.kind == KIND_TICK) ? S_PREP : S_DONE;
            unique case (item_i.kind)
              KIND_TICK: ;
              KIND_NOTE_ON: begin
                amp_cnt_q   <= '0;
                mod_cnt_q   <= '0;
                amp_val_q   <= '0;
                mod_val_q   <= '0;
                peak_q      <= item_i.peak;
                amp_stage_q <= ST_ATTACK;
                mod_stage_q <= ST_ATTACK;
              end
              KIND_RETRIG: begin
                amp_cnt_q   <= '0;
                mod_cnt_q   <= '0;
                peak_q      <= item_i.peak;
                amp_stage_q <= ST_ATTACK;
                mod_stage_q <= ST_ATTACK;
              end
              KIND_LEGATO: begin
                peak_q <= item_i.peak;
                if (amp_stage_q == ST_RELEASE || amp_stage_q == ST_IDLE) begin
                  amp_cnt_q   <= '0;
                  mod_cnt_q   <= '0;
                  amp_stage_q <= ST_ATTACK;
                  mod_stage_q <= ST_ATTACK;
                end
              end
              KIND_NOTE_OFF: begin
                amp_cnt_q   <= '0;
                mod_cnt_q   <= '0;
                amp_stage_q <= ST_RELEASE;
                mod_stage_q <= ST_RELEASE;
              end
              KIND_STOP: begin
                amp_cnt_q   <= '0;
                mod_cnt_q   <= '0;
                amp_val_q   <= '0;
                mod_val_q   <= '0;
                amp_stage_q <= ST_IDLE;
                mod_stage_q <= ST_IDLE;
              end
              default: ;
            endcase
          end
        end
        S_PREP: seq_q <= S_SETUP;
        S_SETUP: seq_q <= S_DIV;
        S_DIV: begin
          if (!amp_busy && !mod_busy) begin
            seq_q <= S_DONE;
            unique case (amp_plan.kind)
              PL_SEG: begin
                if (amp_jump) begin
                  amp_val_q   <= amp_plan.target;
                  amp_cnt_q   <= '0;
                  amp_stage_q <= amp_plan.next;
                end else begin
                  amp_val_q <= amp_sum[LB-1:0];
                  if (amp_fin) begin
                    amp_cnt_q   <= '0;
                    amp_stage_q <= amp_plan.next;
                  end else begin
                    amp_cnt_q <= amp_cnt1[FB-1:0];
                  end
                end
              end
              PL_SET: begin
                amp_val_q   <= amp_plan.target;
                amp_stage_q <= amp_plan.next;
              end
              default: amp_cnt_q <= '0;
            endcase
            unique case (mod_plan.kind)
              PL_SEG: begin
                if (mod_jump) begin
                  mod_val_q   <= mod_plan.target;
                  mod_cnt_q   <= '0;
                  mod_stage_q <= mod_plan.next;
                end else begin
                  mod_val_q <= mod_sum[LB-1:0];
                  if (mod_fin) begin
                    mod_cnt_q   <= '0;
                    mod_stage_q <= mod_plan.next;
                  end else begin
                    mod_cnt_q <= mod_cnt1[FB-1:0];
                  end
                end
              end
              PL_SET: begin
                mod_val_q   <= mod_plan.target;
                mod_stage_q <= mod_plan.next;
              end
              default: mod_cnt_q <= '0;
            endcase
          end
        end
        S_DONE: if (out_load) seq_q <= S_WAIT;
        default: seq_q <= S_WAIT;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (seq_q == S_PREP) prod_q <= 32'(peak_q) * 32'(sat_q15(cfg_i.sustain_level));
    if (out_load) begin
      out_q.amp_level <= amp_val_q[LEVEL_FRAC_BITS -: 16];
      out_q.mod_level <= mod_val_q[LEVEL_FRAC_BITS -: 16];
      out_q.amp_phase <= amp_stage_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== design/dual_adsr_envelope.sv =====
// top level of the dual linear envelope generator with its register file
`default_nettype none
// Two linear ADSR envelopes (amplitude and filter) advance one frame per tick
// transaction; note on, retrigger, legato, note off and stop change state only.
// Every input transaction yields one result transaction. Events go from the
// back end's wait state straight to its done state; a tick passes through the
// prepare, setup and divide states, where a running ramp waits on the two
// bit-serial dividers that run side by side, one quotient bit a cycle.
// A two-entry queue takes input while the back end works, and the output
// register holds a finished result while the next one is computed.
// Configuration writes are accepted every cycle and belong in idle periods.
module dual_adsr_envelope #(
  parameter int unsigned FRAME_BITS      = dae_pkg::FRAME_BITS_DEF,
  parameter int unsigned LEVEL_FRAC_BITS = dae_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dae_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dae_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dae_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dae_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import dae_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK, REG_DECAY, REG_SUSTAIN, REG_RELEASE,
    REG_MOD_ATTACK, REG_MOD_DECAY, REG_MOD_SUSTAIN, REG_MOD_RELEASE
  } reg_idx_e;

  cfg_t  cfg_q;
  logic  item_valid, item_pop;
  item_t item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_frames      <= '0;
      cfg_q.decay_frames       <= '0;
      cfg_q.sustain_level      <= Q15_ONE;
      cfg_q.release_frames     <= '0;
      cfg_q.mod_attack_frames  <= '0;
      cfg_q.mod_decay_frames   <= CFG_FRAME_W'(4800);
      cfg_q.mod_sustain_level  <= '0;
      cfg_q.mod_release_frames <= CFG_FRAME_W'(24000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ATTACK:      cfg_q.attack_frames      <= cfg_data_i;
        REG_DECAY:       cfg_q.decay_frames       <= cfg_data_i;
        REG_SUSTAIN:     cfg_q.sustain_level      <= cfg_data_i[Q15_W-1:0];
        REG_RELEASE:     cfg_q.release_frames     <= cfg_data_i;
        REG_MOD_ATTACK:  cfg_q.mod_attack_frames  <= cfg_data_i;
        REG_MOD_DECAY:   cfg_q.mod_decay_frames   <= cfg_data_i;
        REG_MOD_SUSTAIN: cfg_q.mod_sustain_level  <= cfg_data_i[Q15_W-1:0];
        REG_MOD_RELEASE: cfg_q.mod_release_frames <= cfg_data_i;
      endcase
    end
  end

  dae_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  dae_back #(
    .FRAME_BITS      (FRAME_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// testbench of the dual envelope generator: directed table, random traffic, self-checking
`timescale 1ns / 1ps
module testbench;
  import dae_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0, ST_ATTACK = 3'd1, ST_DECAY = 3'd2,
                         ST_SUSTAIN = 3'd3, ST_RELEASE = 3'd4;
  localparam logic [2:0] ACT_RESERVED = 3'd7;
  localparam int REG_ATTACK = 0, REG_DECAY = 1, REG_SUSTAIN = 2, REG_RELEASE = 3,
                 REG_MOD_ATTACK = 4, REG_MOD_DECAY = 5, REG_MOD_SUSTAIN = 6,
                 REG_MOD_RELEASE = 7;
  localparam int FRAC = LEVEL_FRAC_BITS_DEF;
  localparam longint FRAME_MASK = (64'd1 << FRAME_BITS_DEF) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  in_t in_data = '0;
  out_t out_data;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dual_adsr_envelope i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // envelope state mirrored in the testbench
  longint unsigned regs [8];
  logic [2:0] amp_st, mod_st;
  longint amp_cnt, mod_cnt, amp_lvl, mod_lvl;
  longint unsigned peak_q15;

  out_t levels_q [$];
  int errors = 0;
  int accepted = 0;
  logic use_typed = 1'b0;
  out_t typed_levels = '0;
  logic no_gaps = 1'b0;

  function automatic longint unsigned clip_q15(longint unsigned v);
    return (v > 32768) ? 64'd32768 : v;
  endfunction

  function automatic logic [15:0] to_q15(longint v);
    longint unsigned u;
    u = (v < 0) ? 0 : v;
    return 16'((u >> (FRAC - 15)) & 16'hFFFF);
  endfunction

  function automatic void ramp(inout logic [2:0] st, inout longint cnt, inout longint lvl,
                               input longint frames, input longint target,
                               input logic [2:0] nxt);
    if (cnt >= frames) begin
      lvl = target;
      cnt = 0;
      st = nxt;
    end else begin
      lvl += (target - lvl) / (frames - cnt);
      cnt += 1;
      if (cnt >= frames) begin
        cnt = 0;
        st = nxt;
      end
    end
  endfunction

  function automatic void reset_envelopes();
    regs = '{0, 0, 32768, 0, 0, 4800, 0, 24000};
    amp_st = ST_IDLE; mod_st = ST_IDLE;
    amp_cnt = 0; mod_cnt = 0; amp_lvl = 0; mod_lvl = 0; peak_q15 = 0;
  endfunction

  function automatic void start_attacks();
    amp_cnt = 0; mod_cnt = 0;
    amp_st = ST_ATTACK; mod_st = ST_ATTACK;
  endfunction

  function automatic void advance_frame();
    longint pk, amp_sus, mod_sus;
    longint unsigned prod;
    pk = longint'(peak_q15 << (FRAC - 15));
    prod = peak_q15 * clip_q15(regs[REG_SUSTAIN]);
    amp_sus = longint'((prod << FRAC) >> 30);
    mod_sus = longint'(clip_q15(regs[REG_MOD_SUSTAIN]) << (FRAC - 15));
    case (amp_st)
      ST_ATTACK:  ramp(amp_st, amp_cnt, amp_lvl, regs[REG_ATTACK] & FRAME_MASK, pk, ST_DECAY);
      ST_DECAY:   ramp(amp_st, amp_cnt, amp_lvl, regs[REG_DECAY] & FRAME_MASK, amp_sus,
                       ST_SUSTAIN);
      ST_SUSTAIN: amp_lvl = amp_sus;
      ST_RELEASE: ramp(amp_st, amp_cnt, amp_lvl, regs[REG_RELEASE] & FRAME_MASK, 0, ST_IDLE);
      default: begin
        amp_st = ST_IDLE;
        amp_lvl = 0;
      end
    endcase
    case (mod_st)
      ST_ATTACK:  ramp(mod_st, mod_cnt, mod_lvl, regs[REG_MOD_ATTACK] & FRAME_MASK,
                       longint'(64'd32768 << (FRAC - 15)), ST_DECAY);
      ST_DECAY:   ramp(mod_st, mod_cnt, mod_lvl, regs[REG_MOD_DECAY] & FRAME_MASK, mod_sus,
                       ST_SUSTAIN);
      ST_SUSTAIN: mod_lvl = mod_sus;
      ST_RELEASE: ramp(mod_st, mod_cnt, mod_lvl, regs[REG_MOD_RELEASE] & FRAME_MASK, 0,
                       ST_IDLE);
      default: begin
        mod_st = ST_IDLE;
        mod_cnt = 0;
      end
    endcase
  endfunction

  function automatic out_t envelope_step(in_t it);
    out_t r;
    longint unsigned pin;
    pin = clip_q15(it.peak_level);
    case (it.action)
      KIND_TICK: advance_frame();
      KIND_NOTE_ON: begin
        start_attacks();
        amp_lvl = 0; mod_lvl = 0; peak_q15 = pin;
      end
      KIND_RETRIG: begin
        start_attacks();
        peak_q15 = pin;
      end
      KIND_LEGATO: begin
        peak_q15 = pin;
        if (amp_st == ST_RELEASE || amp_st == ST_IDLE) start_attacks();
      end
      KIND_NOTE_OFF: begin
        amp_cnt = 0; mod_cnt = 0;
        amp_st = ST_RELEASE; mod_st = ST_RELEASE;
      end
      KIND_STOP: begin
        amp_cnt = 0; mod_cnt = 0; amp_lvl = 0; mod_lvl = 0;
        amp_st = ST_IDLE; mod_st = ST_IDLE;
      end
      default: ;
    endcase
    r.amp_level = to_q15(amp_lvl);
    r.mod_level = to_q15(mod_lvl);
    r.amp_phase = amp_st;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // transaction monitor: predict on input, compare on output
  always @(posedge clk_i) begin
    out_t pred, want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        pred = envelope_step(in_data);
        levels_q.push_back(use_typed ? typed_levels : pred);
        accepted++;
      end
      if (out_valid && !out_stall) begin
        if (levels_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = levels_q.pop_front();
          if (out_data.amp_level !== want.amp_level)
            report_mismatch("amp_level", out_data.amp_level, want.amp_level);
          if (out_data.mod_level !== want.mod_level)
            report_mismatch("mod_level", out_data.mod_level, want.mod_level);
          if (out_data.amp_phase !== want.amp_phase)
            report_mismatch("amp_phase", out_data.amp_phase, want.amp_phase);
        end
      end
    end
  end

  // receiver stalls, with one long hold-off once traffic is flowing
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (!held && accepted >= 400) begin
        held = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else if (no_gaps) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 99) < 20) ||
                    (out_stall && $urandom_range(0, 99) < 70);
      end
    end
  end

  task automatic idle_gap();
    int n, r;
    r = $urandom_range(0, 99);
    n = no_gaps ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send(logic [2:0] act, logic [15:0] pk, logic typed, out_t tv);
    in_valid = 1'b1;
    in_data.action = act;
    in_data.peak_level = pk;
    use_typed = typed;
    typed_levels = tv;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
    use_typed = 1'b0;
    idle_gap();
  endtask

  task automatic write_reg(int idx, longint unsigned val);
    cfg_valid = 1'b1;
    cfg_index = CFG_IDX_W'(idx);
    cfg_data = CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready);
    regs[idx] = (idx == REG_SUSTAIN || idx == REG_MOD_SUSTAIN) ? (val & 16'hFFFF)
                                                                : (val & FRAME_MASK);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    wait (levels_q.size() == 0);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic longint unsigned pick_frames(int mode);
    case (mode)
      0: return 0;
      1: return FRAME_MASK;
      default: return ($urandom_range(0, 99) < 90) ? $urandom_range(0, 12)
                                                   : $urandom_range(0, 1048575);
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    return (r == 0) ? 16'h0000 : (r == 1) ? 16'h8000 : (r == 2) ? 16'hFFFF
                                                      : 16'($urandom_range(0, 65535));
  endfunction

  typedef struct {
    logic [2:0]  act;
    logic [15:0] pk;
    logic        typed;
    out_t        tv;
  } row_t;

  row_t rows [] = '{
    '{KIND_TICK,     16'h0000, 1, '{16'd0, 16'd0, ST_IDLE}},
    '{KIND_NOTE_ON,  16'hFFFF, 1, '{16'd0, 16'd0, ST_ATTACK}},
    '{KIND_TICK,     16'h0000, 1, '{16'd32768, 16'd32768, ST_DECAY}},
    '{KIND_TICK,     16'h0000, 0, '0},
    '{KIND_LEGATO,   16'd1000, 0, '0},
    '{KIND_TICK,     16'h0000, 0, '0},
    '{KIND_NOTE_OFF, 16'h0000, 0, '0},
    '{KIND_TICK,     16'h0000, 0, '0},
    '{KIND_LEGATO,   16'h8000, 0, '0},
    '{KIND_TICK,     16'h0000, 0, '0},
    '{KIND_RETRIG,   16'h1234, 0, '0},
    '{KIND_NOP,      16'hFFFF, 0, '0},
    '{ACT_RESERVED,  16'h5555, 0, '0},
    '{KIND_TICK,     16'hAAAA, 0, '0},
    '{KIND_STOP,     16'hFFFF, 1, '{16'd0, 16'd0, ST_IDLE}},
    '{KIND_NOTE_ON,  16'h0000, 0, '0},
    '{KIND_TICK,     16'h0000, 0, '0},
    '{KIND_NOTE_ON,  16'h7FFF, 0, '0},
    '{KIND_TICK,     16'h0000, 0, '0},
    '{KIND_TICK,     16'h0000, 0, '0}
  };

  initial begin
    int phase, mode, n, r;
    logic [2:0] act;
    reset_envelopes();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send(rows[i].act, rows[i].pk, rows[i].typed, rows[i].tv);

    for (phase = 0; phase < 8; phase++) begin
      drain();
      mode = (phase == 0) ? 0 : (phase == 1) ? 1 : 2;
      no_gaps = (phase == 3);
      write_reg(REG_ATTACK, pick_frames(mode));
      write_reg(REG_DECAY, pick_frames(mode));
      write_reg(REG_SUSTAIN, (mode == 0) ? 0 : (mode == 1) ? 16'hFFFF : pick_level());
      write_reg(REG_RELEASE, pick_frames(mode));
      write_reg(REG_MOD_ATTACK, pick_frames(mode));
      write_reg(REG_MOD_DECAY, pick_frames(mode));
      write_reg(REG_MOD_SUSTAIN, (mode == 0) ? 0 : (mode == 1) ? 16'hFFFF : pick_level());
      write_reg(REG_MOD_RELEASE, pick_frames(mode));
      n = 0;
      while (n < 185) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          // ignored codes, not counted
          send(($urandom_range(0, 1) != 0) ? ACT_RESERVED : 3'(KIND_NOP),
               16'($urandom_range(0, 65535)), 0, '0);
        end else begin
          act = (r < 60) ? 3'(KIND_TICK) : 3'($urandom_range(1, 5));
          send(act, pick_level(), 0, '0);
          n++;
        end
      end
    end
    no_gaps = 1'b0;
    drain();
    if (errors == 0 && levels_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dae_pkg.sv
design/dae_front.sv
design/dae_div.sv
design/dae_back.sv
design/dual_adsr_envelope.sv
sim/testbench.sv
